[design/ssc_pkg.sv]
// shared types and helper functions for the sphere contact pipeline
// no dependencies; used by sphere_sphere_contact_core
package ssc_pkg;

  localparam int SQRT_STAGES = 35;
  localparam int DIV_STAGES  = 32;
  localparam int LANES       = 6;

  // per-word payload that rides alongside the root extraction
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0]       neg;
    logic [2:0][32:0] mag;
    logic [30:0]      rb;
    logic [31:0]      rsum;
  } carry_t;

  // one root extraction stage
  typedef struct packed {
    logic [69:0] rad;
    logic [37:0] rem;
    logic [34:0] root;
    carry_t      c;
  } sqs_t;

  // payload that rides alongside the dividers
  typedef struct packed {
    logic             touch;
    logic             conc;
    logic [2:0]       neg;
    logic [2:0][31:0] a;
    logic [31:0]      cpush_y;
    logic [31:0]      cpoint_y;
    logic [31:0]      dlen;
  } oc_t;

  // one restoring division lane
  typedef struct packed {
    logic [63:0] num;
    logic [31:0] rem;
    logic [31:0] q;
  } div_t;

  typedef struct packed {
    div_t [LANES-1:0] ln;
    oc_t              c;
  } dvs_t;

  // one digit of the square root: two radicand bits in, one root bit out
  function automatic sqs_t sqrt_step(input sqs_t s);
    sqs_t        o;
    logic [37:0] rem2;
    logic [37:0] trial;
    begin
      o     = s;
      rem2  = {s.rem[35:0], s.rad[69:68]};
      trial = {1'b0, s.root, 2'b01};
      o.rad = {s.rad[67:0], 2'b00};
      if (rem2 >= trial) begin
        o.rem  = rem2 - trial;
        o.root = {s.root[33:0], 1'b1};
      end else begin
        o.rem  = rem2;
        o.root = {s.root[33:0], 1'b0};
      end
      return o;
    end
  endfunction

  // one quotient bit of a 64 by 32 division
  function automatic div_t div_step(input div_t s, input logic [31:0] d);
    div_t        o;
    logic [32:0] rem2;
    begin
      rem2  = {s.rem, s.num[63]};
      o.num = {s.num[62:0], 1'b0};
      if (rem2 >= {1'b0, d}) begin
        o.rem = 32'(rem2 - {1'b0, d});
        o.q   = {s.q[30:0], 1'b1};
      end else begin
        o.rem = rem2[31:0];
        o.q   = {s.q[30:0], 1'b0};
      end
      return o;
    end
  endfunction

  // clamp a 34-bit signed value to the signed 32-bit range
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    begin
      if (v > 34'sh0_7FFF_FFFF)       return 32'h7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) return 32'h8000_0000;
      else                            return v[31:0];
    end
  endfunction

endpackage

[design/sphere_sphere_contact_core.sv]
// sphere pair contact test: root, division and saturation pipeline
// depends on ssc_pkg
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_center_*, in_radius_a, in_radius_b
//  out     | output    | out_valid, out_stall, out_touching, out_push_*, out_point_*
//
// one word enters every cycle unless a valid output stalls; the stages are three
// front stages, one stage per root bit (35), a product stage, one stage per
// quotient bit (32) and an output register. reset clears the valid bits only.
// a stall on a valid output holds every stage at once and raises in_stall.
module sphere_sphere_contact_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_center_a_x,
  input  logic signed [31:0] in_center_a_y,
  input  logic signed [31:0] in_center_a_z,
  input  logic signed [31:0] in_center_b_x,
  input  logic signed [31:0] in_center_b_y,
  input  logic signed [31:0] in_center_b_z,
  input  logic        [30:0] in_radius_a,
  input  logic        [30:0] in_radius_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_touching,
  output logic signed [31:0] out_push_x,
  output logic signed [31:0] out_push_y,
  output logic signed [31:0] out_push_z,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z
);
  import ssc_pkg::*;

  logic adv;

  // front stages
  carry_t       s0_r, s0_nxt, s1_r, s2_r;
  logic [2:0][65:0] s1_sq_r;
  logic [66:0]  s2_sum_r;
  logic         s0_v_r, s1_v_r, s2_v_r;

  // root and divider stages
  sqs_t sq_r [SQRT_STAGES];
  sqs_t sq_in [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] sq_v_r;
  dvs_t dv_r [DIV_STAGES+1];
  logic [DIV_STAGES:0] dv_v_r;
  dvs_t dv_nxt;

  // output register
  logic        o_v_r, o_touch_r;
  logic [31:0] o_px_r, o_py_r, o_pz_r, o_qx_r, o_qy_r, o_qz_r;
  logic [31:0] f_push [3];
  logic [31:0] f_point [3];

  assign adv      = !(o_v_r && out_stall);
  assign in_stall = !adv;

  // stage 0: deltas, magnitudes and radius sum
  always_comb begin
    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [32:0] dl;
    av[0] = in_center_a_x; av[1] = in_center_a_y; av[2] = in_center_a_z;
    bv[0] = in_center_b_x; bv[1] = in_center_b_y; bv[2] = in_center_b_z;
    s0_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      dl = {bv[i][31], bv[i]} - {av[i][31], av[i]};
      s0_nxt.a[i]   = av[i];
      s0_nxt.neg[i] = dl[32];
      s0_nxt.mag[i] = dl[32] ? 33'(-dl) : dl;
    end
    s0_nxt.rb   = in_radius_b;
    s0_nxt.rsum = {1'b0, in_radius_a} + {1'b0, in_radius_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  // stages 1 and 2: squares, then their sum
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
      s1_r <= s0_r;
      for (int i = 0; i < 3; i++) s1_sq_r[i] <= s0_r.mag[i] * s0_r.mag[i];
      s2_r     <= s1_r;
      s2_sum_r <= {1'b0, s1_sq_r[0]} + {1'b0, s1_sq_r[1]} + {1'b0, s1_sq_r[2]};
    end
  end

  // root extraction, one bit per stage
  always_comb begin
    sq_in[0].rad  = {3'b000, s2_sum_r};
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    sq_in[0].c    = s2_r;
    for (int k = 1; k < SQRT_STAGES; k++) sq_in[k] = sq_r[k-1];
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k] <= 1'b0;
        end else if (adv) begin
          sq_v_r[k] <= s2_v_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k] <= 1'b0;
        end else if (adv) begin
          sq_v_r[k] <= sq_v_r[k-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) sq_r[k] <= sqrt_step(sq_in[k]);
    end
  end

  // product stage: overlap test, concentric values and numerators
  always_comb begin
    sqs_t               s;
    logic [34:0]        root_v;
    logic [31:0]        diff;
    logic [63:0]        num;
    logic signed [33:0] py;
    s      = sq_r[SQRT_STAGES-1];
    root_v = s.root;
    diff   = s.c.rsum - root_v[31:0];
    py     = {{2{s.c.a[1][31]}}, s.c.a[1]} - {3'b000, s.c.rb};
    dv_nxt.c.touch    = {3'b000, s.c.rsum} > root_v;
    dv_nxt.c.conc     = (root_v == '0);
    dv_nxt.c.neg      = s.c.neg;
    dv_nxt.c.a        = s.c.a;
    dv_nxt.c.cpush_y  = {1'b0, s.c.rsum[31:1]};
    dv_nxt.c.cpoint_y = sat34(py);
    dv_nxt.c.dlen     = root_v[31:0];
    for (int i = 0; i < LANES; i++) begin
      if (i < 3) num = s.c.mag[i][31:0] * diff;
      else       num = s.c.mag[i-3][31:0] * {1'b0, s.c.rb};
      dv_nxt.ln[i].rem = num[63:32];
      dv_nxt.ln[i].num = {num[31:0], 32'h0};
      dv_nxt.ln[i].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dv_r[0] <= dv_nxt;
  end

  // dividers, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j].c <= dv_r[j-1].c;
        for (int i = 0; i < LANES; i++)
          dv_r[j].ln[i] <= div_step(dv_r[j-1].ln[i], dv_r[j-1].c.dlen);
      end
    end
  end

  // signs and saturation
  always_comb begin
    dvs_t               f;
    logic signed [33:0] pv;
    logic signed [33:0] off;
    f = dv_r[DIV_STAGES];
    for (int i = 0; i < 3; i++) begin
      pv  = f.c.neg[i] ? $signed({2'b00, f.ln[i].q}) : -$signed({2'b00, f.ln[i].q});
      off = f.c.neg[i] ? -$signed({2'b00, f.ln[i+3].q}) : $signed({2'b00, f.ln[i+3].q});
      f_push[i]  = sat34(pv);
      f_point[i] = sat34($signed({{2{f.c.a[i][31]}}, f.c.a[i]}) + off);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= dv_v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    oc_t c;
    c = dv_r[DIV_STAGES].c;
    if (adv) begin
      o_touch_r <= c.touch;
      if (!c.touch) begin
        {o_px_r, o_py_r, o_pz_r, o_qx_r, o_qy_r, o_qz_r} <= '0;
      end else if (c.conc) begin
        o_px_r <= '0;
        o_py_r <= c.cpush_y;
        o_pz_r <= '0;
        o_qx_r <= c.a[0];
        o_qy_r <= c.cpoint_y;
        o_qz_r <= c.a[2];
      end else begin
        o_px_r <= f_push[0];
        o_py_r <= f_push[1];
        o_pz_r <= f_push[2];
        o_qx_r <= f_point[0];
        o_qy_r <= f_point[1];
        o_qz_r <= f_point[2];
      end
    end
  end

  assign out_valid    = o_v_r;
  assign out_touching = o_touch_r;
  assign out_push_x   = o_px_r;
  assign out_push_y   = o_py_r;
  assign out_push_z   = o_pz_r;
  assign out_point_x  = o_qx_r;
  assign out_point_y  = o_qy_r;
  assign out_point_z  = o_qz_r;

endmodule

[design/ssc_chk.sv]
// port-level checks for sphere_sphere_contact_core, with its bind
// depends on sphere_sphere_contact_core being compiled first
module ssc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_touching,
  input logic signed [31:0] out_push_x,
  input logic signed [31:0] out_push_y,
  input logic signed [31:0] out_push_z,
  input logic signed [31:0] out_point_x,
  input logic signed [31:0] out_point_y,
  input logic signed [31:0] out_point_z
);

  // input back-pressure follows a held result exactly
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  // a word without contact carries only zeros
  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_touching) |->
      (out_push_x == 0 && out_push_y == 0 && out_push_z == 0 &&
       out_point_x == 0 && out_point_y == 0 && out_point_z == 0))
    else $error("separated result with non-zero fields");

  // a stalled result stays valid, with push_x and point_y unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_push_x) && $stable(out_point_y)))
    else $error("stalled result changed");

endmodule

bind sphere_sphere_contact_core ssc_chk u_ssc_chk (.*);

[tb/sv/testbench.sv]
// self-checking bench for sphere_sphere_contact_core: random and directed sphere pairs
// depends on the core (and ssc_pkg through it); predicts contact results in plain sv

module testbench;

  // one expected result word
  typedef struct {
    logic        touching;
    logic [31:0] push[3];
    logic [31:0] point[3];
  } contact_t;

  int unsigned err_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("mismatch %s: got %h want %h", what, got, exp_v);
    err_count++;
  endtask

  // clamp to signed 32 bits
  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // floor square root of a sum below 2^66
  function automatic longint unsigned floor_root(input logic [67:0] s);
    logic [33:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = {1'b0, r} | (35'd1 << b);
      if ({35'd0, c} * {35'd0, c} <= {2'b0, s}) r = c[33:0];
    end
    return 64'(r);
  endfunction

  function automatic contact_t predict_contact(input logic signed [31:0] ca[3],
      input logic signed [31:0] cb[3], input logic [30:0] ra, input logic [30:0] rb);
    contact_t o;
    longint d[3];
    longint unsigned mag[3], dlen, rsum, qp, qc;
    logic [67:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(cb[i]) - longint'(ca[i]);
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      s += 68'(mag[i]) * 68'(mag[i]);
    end
    rsum = 64'(ra) + 64'(rb);
    dlen = floor_root(s);
    o.touching = 0;
    for (int i = 0; i < 3; i++) begin
      o.push[i] = 0;
      o.point[i] = 0;
    end
    if (dlen >= rsum) return o;
    o.touching = 1;
    if (dlen == 0) begin
      // concentric pair
      o.push[1] = clamp32(longint'(rsum >> 1));
      o.point[0] = ca[0];
      o.point[1] = clamp32(longint'(ca[1]) - longint'(rb));
      o.point[2] = ca[2];
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      qp = (mag[i] * (rsum - dlen)) / dlen;
      qc = (mag[i] * 64'(rb)) / dlen;
      o.push[i] = clamp32(d[i] < 0 ? longint'(qp) : -longint'(qp));
      o.point[i] = clamp32(longint'(ca[i]) + (d[i] < 0 ? -longint'(qc) : longint'(qc)));
    end
    return o;
  endfunction

  class contact_scoreboard;
    contact_t pending[$];
    int unsigned n_checked = 0, n_touch = 0;

    function void note_input(input logic signed [31:0] ca[3], input logic signed [31:0] cb[3],
        input logic [30:0] ra, input logic [30:0] rb);
      pending.push_back(predict_contact(ca, cb, ra, rb));
    endfunction

    task check_result(input contact_t got);
      contact_t e;
      if (pending.size() == 0) begin
        report("unexpected result word", '0, '0);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (e.touching) n_touch++;
      if (got.touching !== e.touching) report("touching", got.touching, e.touching);
      for (int i = 0; i < 3; i++) begin
        if (got.push[i] !== e.push[i]) report($sformatf("push[%0d]", i), got.push[i], e.push[i]);
        if (got.point[i] !== e.point[i])
          report($sformatf("point[%0d]", i), got.point[i], e.point[i]);
      end
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, out_touching;
  logic signed [31:0] ca_q[3], cb_q[3];
  logic [30:0] ra_q = 0, rb_q = 0;
  logic signed [31:0] push_x, push_y, push_z, point_x, point_y, point_z;

  sphere_sphere_contact_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_center_a_x(ca_q[0]), .in_center_a_y(ca_q[1]), .in_center_a_z(ca_q[2]),
    .in_center_b_x(cb_q[0]), .in_center_b_y(cb_q[1]), .in_center_b_z(cb_q[2]),
    .in_radius_a(ra_q), .in_radius_b(rb_q),
    .out_valid(out_valid), .out_stall(out_stall), .out_touching(out_touching),
    .out_push_x(push_x), .out_push_y(push_y), .out_push_z(push_z),
    .out_point_x(point_x), .out_point_y(point_y), .out_point_z(point_z)
  );

  contact_scoreboard sb = new();
  int send_idle = 19, recv_idle = 54;
  bit hold_off = 0, stim_done = 0;
  int unsigned quiet = 0;
  localparam int QUIET_LIMIT = 5000;

  initial begin
    for (int i = 0; i < 3; i++) begin
      ca_q[i] = 0;
      cb_q[i] = 0;
    end
    forever #1 clk = ~clk;
  end

  // random value biased towards small coordinates so contacts are common
  function automatic logic [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // present one word and wait for it to be taken; valid drops only in idle gaps
  task automatic send_word(input logic signed [31:0] ca[3], input logic signed [31:0] cb[3],
      input logic [30:0] ra, input logic [30:0] rb);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    ca_q = ca; cb_q = cb; ra_q = ra; rb_q = rb;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(ca, cb, ra, rb);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    logic signed [31:0] ca[3], cb[3];
    logic [30:0] ra, rb;
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) + 1);
      for (int i = 0; i < 3; i++) begin
        ca[i] = rnd_coord(mode);
        cb[i] = $urandom_range(0, 19) == 0 ? ca[i] : rnd_coord(mode);
      end
      case ($urandom_range(0, 5))
        0: begin ra = 31'($urandom()); rb = 31'($urandom()); end
        1: begin ra = 0; rb = 31'($urandom_range(0, 3)); end
        default: begin
          ra = mode == 1 ? 31'($urandom_range(0, 32'h0003_0000))
                         : 31'($urandom_range(0, 32'h0180_0000));
          rb = mode == 1 ? 31'($urandom_range(0, 32'h0003_0000))
                         : 31'($urandom_range(0, 32'h0180_0000));
        end
      endcase
      send_word(ca, cb, ra, rb);
    end
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // receiver stall process
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle);
  end

  // result sampling
  always @(posedge clk) begin
    contact_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.touching = out_touching;
      got.push[0] = push_x; got.push[1] = push_y; got.push[2] = push_z;
      got.point[0] = point_x; got.point[1] = point_y; got.point[2] = point_z;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else if (rst_n && !hold_off) quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    wait (stim_done == 0 && rst_n);
    repeat (300) @(negedge clk);
    hold_off = 1;
    repeat (250) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    logic signed [31:0] ca[3], cb[3];
    repeat (3) @(negedge clk);
    rst_n = 1;
    // directed corners
    for (int i = 0; i < 3; i++) begin ca[i] = 0; cb[i] = 0; end
    send_word(ca, cb, 0, 0);                             // equal centres, zero radii
    send_word(ca, cb, 31'h7FFF_FFFF, 31'h7FFF_FFFF);      // concentric, saturated push
    ca[1] = 32'sh8000_0000; cb[1] = 32'sh8000_0000;
    send_word(ca, cb, 1, 31'h7FFF_FFFF);                  // concentric, point_y saturates low
    ca[1] = 32'sh8000_0000; cb[1] = 32'sh7FFF_FFFF;
    send_word(ca, cb, 31'h7FFF_FFFF, 31'h7FFF_FFFF);      // widest gap, separated
    for (int i = 0; i < 3; i++) begin ca[i] = 32'sh8000_0000; cb[i] = 32'sh7FFF_FFFF; end
    send_word(ca, cb, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    for (int i = 0; i < 3; i++) begin ca[i] = 32'sh0001_0000; cb[i] = 32'sh0001_0001; end
    send_word(ca, cb, 31'h7FFF_FFFF, 31'h7FFF_FFFF);      // tiny gap, huge push
    cb[0] = 32'sh0000_0000; cb[1] = 32'sh0003_0000;
    send_word(ca, cb, 31'h0002_0000, 31'h0001_8000);      // overlap, mixed signs
    send_word(ca, cb, 31'h0000_8000, 31'h0000_8000);      // separated
    cb[0] = 32'sh0001_0000; cb[1] = 32'sh0002_0000; cb[2] = 32'sh0001_0000;
    send_word(ca, cb, 31'h0000_8000, 31'h0000_8000);      // gap exactly R
    send_word(ca, cb, 31'h0000_8000, 31'h0000_8001);      // just inside
    // random phases with the three idle profiles
    send_random(400);
    send_idle = 54; recv_idle = 19;
    send_random(400);
    send_idle = 0; recv_idle = 0;
    send_random(400);
    in_valid <= 0;
    stim_done = 1;
    drain();
    repeat (100) @(posedge clk);
    $display("checked %0d result words, %0d of them in contact", sb.n_checked, sb.n_touch);
    if (err_count == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
design/ssc_pkg.sv
design/sphere_sphere_contact_core.sv
design/ssc_chk.sv
tb/sv/testbench.sv
